// File: rtl/puc_pkg.sv
package puc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [3:0] NibbleMask = 4'd15;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [0:0] REG_DIRECTION_MODE = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_AFTER_PC = 2'd1,
    PH_AFTER_HI = 2'd2
  } esc_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HIGH = 2'd1,
    BK_LOW  = 2'd2
  } back_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // One queued job: either a single beat, or a three-beat escape of data.
  typedef struct packed {
    logic       esc;
    logic       err;
    logic       last;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: rtl/percent_url_codec_unit.sv
// A result beat passes through the job queue and the registered output stage.
// Input takes one beat per cycle while the four-entry job queue between front
// and back is not full; an encoded escape emits three output beats, so input
// stalls once that queue fills.
// Reset: asynchronous, active low; clears mode to encode, escape state, queue.
module percent_url_codec_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  puc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output puc_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          mode_q, mode_d;
  logic          cfg_wr;
  logic          push;
  puc_pkg::cmd_t push_cmd;
  logic          full;
  logic          nonempty;
  logic          pop;
  puc_pkg::cmd_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  paddr[2] == puc_pkg::REG_DIRECTION_MODE;
  assign mode_d = cfg_wr ? pwdata[0] : mode_q;
  assign prdata = (paddr[2] == puc_pkg::REG_DIRECTION_MODE) ? {31'd0, mode_q} : 32'd0;
  assign in_stall_o = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= puc_pkg::MODE_ENCODE;
    end else begin
      mode_q <= mode_d;
    end
  end

  puc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .cfg_clr_i  (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_stall_i (full),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  puc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .nonempty_o (nonempty),
    .pop_i      (pop),
    .head_o     (head)
  );

  puc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/puc_front.sv
module puc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic               cfg_clr_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  puc_pkg::in_item_t  in_data_i,
  output logic               push_o,
  output puc_pkg::cmd_t      push_cmd_o
);

  puc_pkg::esc_phase_e phase_q, phase_d;
  logic [3:0]          hi_q, hi_d;
  logic                accept;
  logic [7:0]          b;
  logic                last;
  logic                plain;
  logic                hex_ok;
  logic [3:0]          hex_val;

  assign accept = in_valid_i && !in_stall_i;
  assign b      = in_data_i.in_byte;
  assign last   = in_data_i.in_last;

  always_comb begin
    plain = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
            b == puc_pkg::ChDash || b == puc_pkg::ChUnder ||
            b == puc_pkg::ChDot  || b == puc_pkg::ChTilde;
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      hex_val = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Next escape state.
  always_comb begin
    phase_d = phase_q;
    hi_d    = hi_q;
    if (cfg_clr_i) begin
      phase_d = puc_pkg::PH_IDLE;
      hi_d    = 4'd0;
    end else if (accept && mode_i == puc_pkg::MODE_DECODE) begin
      case (phase_q)
        puc_pkg::PH_AFTER_PC: begin
          if (!hex_ok || last) begin
            phase_d = puc_pkg::PH_IDLE;
            hi_d    = 4'd0;
          end else begin
            phase_d = puc_pkg::PH_AFTER_HI;
            hi_d    = hex_val & puc_pkg::NibbleMask;
          end
        end
        puc_pkg::PH_AFTER_HI: begin
          phase_d = puc_pkg::PH_IDLE;
          hi_d    = 4'd0;
        end
        default: begin
          phase_d = (b == puc_pkg::ChPercent && !last) ? puc_pkg::PH_AFTER_PC
                                                        : puc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Job for the back end.
  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = '{esc: 1'b0, err: 1'b0, last: last, data: b};
    if (accept) begin
      if (mode_i == puc_pkg::MODE_ENCODE) begin
        push_o = 1'b1;
        if (b == puc_pkg::ChSpace) begin
          push_cmd_o.data = puc_pkg::ChPlus;
        end else if (!plain) begin
          push_cmd_o.esc = 1'b1;
        end
      end else begin
        case (phase_q)
          puc_pkg::PH_AFTER_PC: begin
            if (!hex_ok || last) begin
              push_o          = 1'b1;
              push_cmd_o.err  = 1'b1;
              push_cmd_o.data = 8'd0;
            end
          end
          puc_pkg::PH_AFTER_HI: begin
            push_o = 1'b1;
            if (!hex_ok) begin
              push_cmd_o.err  = 1'b1;
              push_cmd_o.data = 8'd0;
            end else begin
              push_cmd_o.data = {hi_q, hex_val};
            end
          end
          default: begin
            if (b == puc_pkg::ChPercent) begin
              if (last) begin
                push_o          = 1'b1;
                push_cmd_o.err  = 1'b1;
                push_cmd_o.data = 8'd0;
              end
            end else begin
              push_o = 1'b1;
              if (b == puc_pkg::ChPlus) begin
                push_cmd_o.data = puc_pkg::ChSpace;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= puc_pkg::PH_IDLE;
      hi_q    <= 4'd0;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// File: rtl/puc_queue.sv
module puc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  puc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          nonempty_o,
  input  logic          pop_i,
  output puc_pkg::cmd_t head_o
);

  puc_pkg::cmd_t                       mem_q [puc_pkg::QueueDepth];
  logic [puc_pkg::QueuePtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [puc_pkg::QueueCntW-1:0]       cnt_q, cnt_d;
  logic                                do_pop;

  assign full_o     = cnt_q == puc_pkg::QueueCntW'(puc_pkg::QueueDepth);
  assign nonempty_o = cnt_q != '0;
  assign head_o     = mem_q[rd_q];
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/puc_back.sv
module puc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               nonempty_i,
  input  puc_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output puc_pkg::out_item_t out_data_o
);

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'd0, v};
    end else begin
      d = 8'h37 + {4'd0, v};
    end
    return d;
  endfunction

  puc_pkg::back_phase_e phase_q, phase_d;
  logic [7:0]           esc_byte_q, esc_byte_d;
  logic                 esc_last_q, esc_last_d;
  logic                 valid_q, valid_d;
  puc_pkg::out_item_t   out_q, out_d;
  logic                 slot_free;

  assign slot_free   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    esc_byte_d = esc_byte_q;
    esc_last_d = esc_last_q;
    if (slot_free) begin
      case (phase_q)
        puc_pkg::BK_HIGH: phase_d = puc_pkg::BK_LOW;
        puc_pkg::BK_LOW:  phase_d = puc_pkg::BK_IDLE;
        default: begin
          if (nonempty_i && head_i.esc) begin
            phase_d    = puc_pkg::BK_HIGH;
            esc_byte_d = head_i.data;
            esc_last_d = head_i.last;
          end
        end
      endcase
    end
  end

  // Output beat and queue pop.
  always_comb begin
    pop_o   = 1'b0;
    valid_d = valid_q && out_stall_i;
    out_d   = out_q;
    if (slot_free) begin
      case (phase_q)
        puc_pkg::BK_HIGH: begin
          valid_d = 1'b1;
          out_d   = '{out_byte: hex_digit(esc_byte_q[7:4]), out_last: 1'b0,
                      out_error: 1'b0};
        end
        puc_pkg::BK_LOW: begin
          valid_d = 1'b1;
          out_d   = '{out_byte: hex_digit(esc_byte_q[3:0]), out_last: esc_last_q,
                      out_error: 1'b0};
        end
        default: begin
          if (nonempty_i) begin
            pop_o   = 1'b1;
            valid_d = 1'b1;
            if (head_i.esc) begin
              out_d = '{out_byte: puc_pkg::ChPercent, out_last: 1'b0, out_error: 1'b0};
            end else begin
              out_d = '{out_byte: head_i.data, out_last: head_i.last,
                        out_error: head_i.err};
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    esc_byte_q <= esc_byte_d;
    esc_last_q <= esc_last_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= puc_pkg::BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

endmodule
